>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the button tap/hold controller.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bdthc_pkg.sv
// Package for the button tap/hold controller: item types, state codes,
// register indexes and limits. No dependencies.
`default_nettype none

package bdthc_pkg;

    typedef logic [2:0]  state_code_t;
    typedef logic [1:0]  cfg_index_t;
    typedef logic [15:0] ms16_t;
    typedef logic [31:0] ms32_t;

    localparam state_code_t ST_ON    = 3'd0;
    localparam state_code_t ST_KILL  = 3'd1;
    localparam state_code_t ST_START = 3'd2;
    localparam state_code_t ST_IDLE  = 3'd3;
    localparam state_code_t ST_FWD   = 3'd4;
    localparam state_code_t ST_REV   = 3'd5;

    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam cfg_index_t CFG_PRESS_DEBOUNCE   = 2'd0;
    localparam cfg_index_t CFG_RELEASE_DEBOUNCE = 2'd1;
    localparam cfg_index_t CFG_HOLD_MIN         = 2'd2;

    localparam ms16_t PRESS_DEBOUNCE_RESET   = 16'd68;
    localparam ms16_t RELEASE_DEBOUNCE_RESET = 16'd68;
    localparam ms16_t HOLD_MIN_RESET         = 16'd900;

    localparam logic signed [15:0] ROT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] ROT_MIN = -16'sh8000;

    localparam int NUM_BUTTONS = 3;
    localparam int BTN_START   = 0;
    localparam int BTN_FWD     = 1;
    localparam int BTN_REV     = 2;

    typedef struct packed {
        logic               op;
        logic               start_level;
        logic               fwd_level;
        logic               rev_level;
        logic [15:0]        elapsed_ms;
        logic [2:0]         write_state;
        logic signed [15:0] write_rotations;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         machine_state;
        logic signed [15:0] rotations;
        logic               start_pressed;
        logic               fwd_held;
        logic               rev_held;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/button_debounce_tap_hold_control.sv
// Stages: an accepted item enters the input register, then one combinational update
// feeds the result register. Throughput: one item per cycle while the result is not stalled.
// in_ready drops only while the input register holds an item and the result is stalled.
// Reset (rst_n low, asynchronous): buttons released, timers and uptime zero,
// state powered on, rotations zero, debounce 68 ms, hold limit 900 ms.
`default_nettype none
`include "assert_macros.svh"

module button_debounce_tap_hold_control
    import bdthc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire cfg_index_t cfg_index,
    input  wire ms16_t      cfg_data
);

    // Configuration
    ms16_t press_db_reg;
    ms16_t release_db_reg;
    ms16_t hold_min_reg;

    // Input stage
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     advance;

    // Result stage
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // Controller state
    logic [NUM_BUTTONS-1:0] now_reg, now_next;
    ms32_t                  stable_reg [NUM_BUTTONS];
    ms32_t                  stable_next [NUM_BUTTONS];
    logic                   fwd_acc_reg, fwd_acc_next;
    logic                   rev_acc_reg, rev_acc_next;
    ms32_t                  fwd_start_reg, fwd_start_next;
    ms32_t                  rev_start_reg, rev_start_next;
    ms32_t                  uptime_reg, uptime_next;
    state_code_t            mode_reg, mode_next;
    logic signed [15:0]     rot_reg, rot_next;

    // Update helpers
    logic [NUM_BUTTONS-1:0] level;
    logic [32:0]            stable_sum [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] press_ok;
    logic [NUM_BUTTONS-1:0] release_ok;
    logic                   start_release_ok;
    ms32_t                  fwd_len;
    ms32_t                  rev_len;
    logic                   fwd_tap;
    logic                   rev_tap;
    logic signed [15:0]     rot_inc;
    logic signed [15:0]     rot_dec;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign level[BTN_START] = s1_item_reg.start_level;
    assign level[BTN_FWD]   = s1_item_reg.fwd_level;
    assign level[BTN_REV]   = s1_item_reg.rev_level;

    assign rot_inc = (rot_reg == ROT_MAX) ? rot_reg : rot_reg + 16'sd1;
    assign rot_dec = (rot_reg == ROT_MIN) ? rot_reg : rot_reg - 16'sd1;

    always_comb
    begin
        now_next       = now_reg;
        fwd_acc_next   = fwd_acc_reg;
        rev_acc_next   = rev_acc_reg;
        fwd_start_next = fwd_start_reg;
        rev_start_next = rev_start_reg;
        uptime_next    = uptime_reg;
        mode_next      = mode_reg;
        rot_next       = rot_reg;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            stable_next[i] = stable_reg[i];
            stable_sum[i]  = {1'b0, stable_reg[i]} + {17'd0, s1_item_reg.elapsed_ms};
        end

        if (s1_item_reg.op == OP_WRITE)
        begin
            mode_next = s1_item_reg.write_state;
            rot_next  = s1_item_reg.write_rotations;
        end
        else
        begin
            uptime_next = uptime_reg + {16'd0, s1_item_reg.elapsed_ms};
            // Sample: a level change restarts the timer, else add and saturate.
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                now_next[i] = ~level[i];
                if (now_next[i] != now_reg[i])
                    stable_next[i] = '0;
                else if (stable_sum[i][32])
                    stable_next[i] = '1;
                else
                    stable_next[i] = stable_sum[i][31:0];
            end
        end

        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            press_ok[i]   = now_next[i] && (stable_next[i] >= {16'd0, press_db_reg});
            release_ok[i] = !now_next[i] && (stable_next[i] >= {16'd0, release_db_reg});
        end
        start_release_ok = !now_next[BTN_START]
                           && (stable_next[BTN_START] >= {16'd0, press_db_reg});
        fwd_len = uptime_next - fwd_start_reg;
        rev_len = uptime_next - rev_start_reg;
        fwd_tap = fwd_len < {16'd0, hold_min_reg};
        rev_tap = rev_len < {16'd0, hold_min_reg};

        // Checks run in order; the last one that sets the state wins.
        if (s1_item_reg.op == OP_POLL)
        begin
            case (mode_reg)
                ST_ON, ST_KILL:
                begin
                    if (press_ok[BTN_START])
                        mode_next = ST_START;
                end
                ST_START:
                begin
                    if (start_release_ok)
                        mode_next = ST_IDLE;
                end
                ST_IDLE, ST_FWD, ST_REV:
                begin
                    if (mode_reg == ST_FWD && fwd_acc_reg && release_ok[BTN_FWD])
                    begin
                        fwd_acc_next = 1'b0;
                        if (fwd_tap)
                            rot_next = rot_inc;
                        else
                        begin
                            rot_next  = '0;
                            mode_next = ST_IDLE;
                        end
                    end
                    if (mode_reg == ST_REV && rev_acc_reg && release_ok[BTN_REV])
                    begin
                        rev_acc_next = 1'b0;
                        if (rev_tap)
                            rot_next = rot_dec;
                        else
                        begin
                            rot_next  = '0;
                            mode_next = ST_IDLE;
                        end
                    end
                    if (press_ok[BTN_START])
                        mode_next = ST_START;
                    if (!fwd_acc_next && press_ok[BTN_FWD])
                    begin
                        fwd_acc_next   = 1'b1;
                        fwd_start_next = uptime_next;
                        mode_next      = ST_FWD;
                    end
                    if (!rev_acc_next && press_ok[BTN_REV])
                    begin
                        rev_acc_next   = 1'b1;
                        rev_start_next = uptime_next;
                        mode_next      = ST_REV;
                    end
                end
                default:
                begin
                    mode_next = ST_ON;
                end
            endcase
        end

        out_item_next.machine_state = mode_next;
        out_item_next.rotations     = rot_next;
        out_item_next.start_pressed = now_next[BTN_START];
        out_item_next.fwd_held      = fwd_acc_next;
        out_item_next.rev_held      = rev_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_db_reg   <= PRESS_DEBOUNCE_RESET;
            release_db_reg <= RELEASE_DEBOUNCE_RESET;
            hold_min_reg   <= HOLD_MIN_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            now_reg        <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
                stable_reg[i] <= '0;
            fwd_acc_reg    <= 1'b0;
            rev_acc_reg    <= 1'b0;
            fwd_start_reg  <= '0;
            rev_start_reg  <= '0;
            uptime_reg     <= '0;
            mode_reg       <= ST_ON;
            rot_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESS_DEBOUNCE:   press_db_reg   <= cfg_data;
                    CFG_RELEASE_DEBOUNCE: release_db_reg <= cfg_data;
                    CFG_HOLD_MIN:         hold_min_reg   <= cfg_data;
                    default:              ;
                endcase
            end

            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // Commit the item's update together with its result.
            if (advance)
            begin
                now_reg       <= now_next;
                for (int i = 0; i < NUM_BUTTONS; i++)
                    stable_reg[i] <= stable_next[i];
                fwd_acc_reg   <= fwd_acc_next;
                rev_acc_reg   <= rev_acc_next;
                fwd_start_reg <= fwd_start_next;
                rev_start_reg <= rev_start_next;
                uptime_reg    <= uptime_next;
                mode_reg      <= mode_next;
                rot_reg       <= rot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= out_item_next;
    end

    `ASSERT_NEXT(a_poll_known_state, advance && s1_item_reg.op == OP_POLL,
        mode_reg <= ST_REV, "poll left an unknown state")
    `ASSERT_SAME(a_fwd_accept_state, $rose(fwd_acc_reg),
        mode_reg == ST_FWD || mode_reg == ST_REV, "forward press without direction state")
    `ASSERT_SAME(a_result_matches_state, out_valid_reg,
        out_item_reg.machine_state == mode_reg && out_item_reg.rotations == rot_reg
        && out_item_reg.fwd_held == fwd_acc_reg && out_item_reg.rev_held == rev_acc_reg,
        "result register out of step with controller state")

endmodule

`default_nettype wire

>>> tb/sv/bdthc_result_checker.sv
// Result checker for button_debounce_tap_hold_control: mirrors the controller state,
// predicts one result per accepted item and compares it with each accepted result.
// Depends on bdthc_pkg.
module bdthc_result_checker
    import bdthc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire in_item_t   in_item,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire out_item_t  out_item,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire cfg_index_t cfg_index,
    input  wire ms16_t      cfg_data,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 100;

    ms16_t              press_db;
    ms16_t              release_db;
    ms16_t              hold_min;
    logic               pressed   [NUM_BUTTONS];
    ms32_t              stable_ms [NUM_BUTTONS];
    logic               latched   [NUM_BUTTONS];   // start entry never used
    ms32_t              press_t0  [NUM_BUTTONS];
    ms32_t              uptime;
    state_code_t        mode;
    logic signed [15:0] rot;
    out_item_t          expected_results [$];
    int                 fail_count = 0;

    function automatic void clear_model();
        press_db   = PRESS_DEBOUNCE_RESET;
        release_db = RELEASE_DEBOUNCE_RESET;
        hold_min   = HOLD_MIN_RESET;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            pressed[b]   = 1'b0;
            stable_ms[b] = '0;
            latched[b]   = 1'b0;
            press_t0[b]  = '0;
        end
        uptime = '0;
        mode   = ST_ON;
        rot    = '0;
    endfunction

    function automatic logic settled(int b, ms16_t limit);
        return stable_ms[b] >= {16'd0, limit};
    endfunction

    function automatic void sample_button(int b, logic now_pressed, ms32_t el);
        logic [32:0] sum;
        sum = {1'b0, stable_ms[b]} + {1'b0, el};
        // hold the counter at all ones instead of wrapping
        if (now_pressed == pressed[b])
            stable_ms[b] = sum[32] ? '1 : sum[31:0];
        else
            stable_ms[b] = '0;
        pressed[b] = now_pressed;
    endfunction

    function automatic void check_start_press();
        if (pressed[BTN_START] && settled(BTN_START, press_db))
            mode = ST_START;
    endfunction

    function automatic void check_start_release();
        if (!pressed[BTN_START] && settled(BTN_START, press_db))
            mode = ST_IDLE;
    endfunction

    function automatic void check_dir_release(int b);
        ms32_t held;
        int    r;
        if (latched[b] && !pressed[b] && settled(b, release_db))
        begin
            held       = uptime - press_t0[b];
            latched[b] = 1'b0;
            if (held < {16'd0, hold_min})
            begin
                r = int'(rot) + ((b == BTN_FWD) ? 1 : -1);
                if (r > int'(ROT_MAX))
                    r = int'(ROT_MAX);
                if (r < int'(ROT_MIN))
                    r = int'(ROT_MIN);
                rot = r[15:0];
            end
            else
            begin
                rot  = '0;
                mode = ST_IDLE;
            end
        end
    endfunction

    function automatic void check_dir_press(int b);
        if (!latched[b] && pressed[b] && settled(b, press_db))
        begin
            latched[b]  = 1'b1;
            press_t0[b] = uptime;
            mode        = (b == BTN_FWD) ? ST_FWD : ST_REV;
        end
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        ms32_t     el;
        out_item_t res;
        if (it.op == OP_WRITE)
        begin
            mode = it.write_state;
            rot  = it.write_rotations;
        end
        else
        begin
            el     = {16'd0, it.elapsed_ms};
            uptime = uptime + el;
            sample_button(BTN_START, !it.start_level, el);
            sample_button(BTN_FWD, !it.fwd_level, el);
            sample_button(BTN_REV, !it.rev_level, el);
            // later checks override the state set by earlier ones
            case (mode)
                ST_ON, ST_KILL:
                    check_start_press();
                ST_START:
                    check_start_release();
                ST_IDLE:
                begin
                    check_start_press();
                    check_dir_press(BTN_FWD);
                    check_dir_press(BTN_REV);
                end
                ST_FWD, ST_REV:
                begin
                    check_dir_release((mode == ST_FWD) ? BTN_FWD : BTN_REV);
                    check_start_press();
                    check_dir_press(BTN_FWD);
                    check_dir_press(BTN_REV);
                end
                default:
                    mode = ST_ON;
            endcase
        end
        res.machine_state = mode;
        res.rotations     = rot;
        res.start_pressed = pressed[BTN_START];
        res.fwd_held      = latched[BTN_FWD];
        res.rev_held      = latched[BTN_REV];
        return res;
    endfunction

    function automatic string describe(out_item_t r);
        return $sformatf("state=%0d rot=%0d start=%b fwd=%b rev=%b", r.machine_state,
                         r.rotations, r.start_pressed, r.fwd_held, r.rev_held);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            clear_model();
            expected_results.delete();
            pending <= 0;
            errors  <= fail_count;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESS_DEBOUNCE:   press_db   = cfg_data;
                    CFG_RELEASE_DEBOUNCE: release_db = cfg_data;
                    CFG_HOLD_MIN:         hold_min   = cfg_data;
                    default: ;
                endcase
            end
            // drain before predicting: a result always belongs to an older item
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: result with no item outstanding, got %s",
                                 $time, describe(out_item));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t ns: mismatch, expected %s, got %s",
                                     $time, describe(want), describe(out_item));
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(in_item));
            pending <= expected_results.size();
            errors  <= fail_count;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for button_debounce_tap_hold_control: clock, reset, item and
// register stimulus with random bursts and stalls, and the final verdict.
// Depends on bdthc_pkg, the block and bdthc_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bdthc_pkg::*;

    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          LONG_HOLDOFF = 80;
    localparam int          SOAK_POLLS   = 20;
    localparam ms16_t       MS_MAX       = 16'hFFFF;
    localparam state_code_t ST_UNDEF_LO  = 3'd6;
    localparam state_code_t ST_UNDEF_HI  = 3'd7;
    localparam cfg_index_t  CFG_SPARE    = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    ms16_t      cfg_data;
    int         errors;
    int         pending;

    int   cycle_count  = 0;
    int   holdoff_req  = 0;
    int   holdoff_seen = 0;
    int   stall_left   = 0;
    int   stretch_left = 0;
    int   ready_pct    = 100;
    int   burst_left   = 0;
    bit   no_gaps      = 1'b0;
    logic start_lvl    = 1'b1;
    logic fwd_lvl      = 1'b1;
    logic rev_lvl      = 1'b1;

    button_debounce_tap_hold_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bdthc_result_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[button_debounce_tap_hold_control] ERROR");
            $finish;
        end
    end

    // Result side: stretches of varying readiness, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (holdoff_seen != holdoff_req)
        begin
            holdoff_seen = holdoff_req;
            stall_left   = LONG_HOLDOFF;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(8, 80);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 70;
                    2:       ready_pct = 40;
                    default: ready_pct = 15;
                endcase
            end
            stretch_left--;
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    function automatic in_item_t poll_item(bit sp, bit fp, bit rp, ms16_t ms);
        in_item_t it;
        it             = '0;
        it.op          = OP_POLL;
        it.start_level = !sp;
        it.fwd_level   = !fp;
        it.rev_level   = !rp;
        it.elapsed_ms  = ms;
        return it;
    endfunction

    function automatic in_item_t write_item(state_code_t st, logic signed [15:0] rv);
        in_item_t it;
        it                 = '0;
        it.op              = OP_WRITE;
        it.start_level     = 1'b1;
        it.fwd_level       = 1'b1;
        it.rev_level       = 1'b1;
        it.write_state     = st;
        it.write_rotations = rv;
        return it;
    endfunction

    // Mostly polls with slowly changing levels; fields the op ignores get noise.
    function automatic in_item_t random_item(int max_ms);
        in_item_t it;
        it.write_state     = 3'($urandom_range(0, 7));
        it.write_rotations = 16'($urandom);
        if ($urandom_range(0, 15) == 0)
        begin
            it.op          = OP_WRITE;
            it.start_level = 1'($urandom);
            it.fwd_level   = 1'($urandom);
            it.rev_level   = 1'($urandom);
            it.elapsed_ms  = 16'($urandom);
            case ($urandom_range(0, 3))
                0:       it.write_rotations = ROT_MAX - 16'($urandom_range(0, 2));
                1:       it.write_rotations = ROT_MIN + 16'($urandom_range(0, 2));
                2:       it.write_rotations = 16'($urandom_range(0, 6)) - 16'd3;
                default: it.write_rotations = 16'($urandom);
            endcase
        end
        else
        begin
            it.op = OP_POLL;
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 4))
                    0:       start_lvl = ~start_lvl;
                    1, 2:    fwd_lvl   = ~fwd_lvl;
                    default: rev_lvl   = ~rev_lvl;
                endcase
            end
            it.start_level = start_lvl;
            it.fwd_level   = fwd_lvl;
            it.rev_level   = rev_lvl;
            case ($urandom_range(0, 9))
                0:       it.elapsed_ms = '0;
                1:       it.elapsed_ms = 16'($urandom);
                default: it.elapsed_ms = 16'($urandom_range(1, max_ms));
            endcase
        end
        return it;
    endfunction

    // Hold valid and payload until the item is taken.
    task automatic offer_item(input in_item_t it);
        int gap;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_random(int count, int max_ms);
        repeat (count)
            offer_item(random_item(max_ms));
    endtask

    task automatic write_reg(input cfg_index_t idx, input ms16_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(ms16_t press_ms, ms16_t release_ms, ms16_t hold_ms);
        write_reg(CFG_PRESS_DEBOUNCE, press_ms);
        write_reg(CFG_RELEASE_DEBOUNCE, release_ms);
        write_reg(CFG_HOLD_MIN, hold_ms);
    endtask

    // Stop offering items and wait until every result is back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PRESS_DEBOUNCE;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset timing: 68 ms debounce, 900 ms hold limit
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(poll_item(1, 0, 0, 0));
        offer_item(poll_item(1, 0, 0, 67));
        offer_item(poll_item(1, 0, 0, 1));       // press reaches the debounce exactly
        offer_item(poll_item(0, 0, 0, 68));      // level change clears the counter
        offer_item(poll_item(0, 0, 0, 68));
        offer_item(poll_item(0, 1, 0, 0));
        offer_item(poll_item(0, 1, 0, 68));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(poll_item(0, 0, 0, 68));      // tap
        offer_item(poll_item(0, 0, 1, 0));
        offer_item(poll_item(0, 0, 1, 68));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(poll_item(0, 0, 0, 832));     // press length 832 ms, under the hold limit: a tap
        offer_item(write_item(ST_REV, ROT_MIN));
        offer_item(poll_item(0, 0, 1, 0));
        offer_item(poll_item(0, 0, 1, 68));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(poll_item(0, 0, 0, 68));      // tap at the negative limit
        offer_item(write_item(ST_FWD, ROT_MAX));
        offer_item(poll_item(0, 1, 0, 0));
        offer_item(poll_item(0, 1, 0, 68));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(poll_item(0, 0, 0, 68));      // tap at the positive limit
        offer_item(write_item(ST_UNDEF_LO, 16'sh5555));
        offer_item(poll_item(1, 1, 1, MS_MAX));
        offer_item(write_item(ST_UNDEF_HI, 16'shAAAA));
        offer_item(poll_item(0, 0, 0, 0));

        wait_idle();
        set_timing(16'd20, 16'd30, 16'd200);
        run_random(250, 60);

        wait_idle();
        set_timing(16'd0, 16'd0, 16'd0);
        run_random(150, 40);

        wait_idle();
        set_timing(MS_MAX, MS_MAX, MS_MAX);
        run_random(100, 40000);

        // Hold forward across many maximum-length polls: the release is a hold.
        wait_idle();
        set_timing(16'd0, 16'd0, 16'd900);
        no_gaps = 1'b1;
        offer_item(write_item(ST_FWD, '0));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(write_item(ST_REV, '0));
        offer_item(poll_item(0, 0, 0, 0));
        offer_item(write_item(ST_IDLE, '0));
        offer_item(poll_item(0, 1, 0, 10));
        repeat (SOAK_POLLS)
            offer_item(poll_item(0, 1, 0, MS_MAX));
        offer_item(poll_item(0, 1, 0, 101));
        offer_item(poll_item(0, 0, 0, 0));
        no_gaps = 1'b0;

        wait_idle();
        set_timing(16'd5, 16'd3, 16'd50);
        write_reg(CFG_SPARE, 16'h1234);
        run_random(150, 20);
        // fill the block while the result side holds off
        holdoff_req++;
        no_gaps = 1'b1;
        run_random(40, 20);
        no_gaps = 1'b0;
        run_random(110, 20);

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[button_debounce_tap_hold_control] OK");
        else
            $display("[button_debounce_tap_hold_control] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/bdthc_pkg.sv
sv/button_debounce_tap_hold_control.sv
tb/sv/bdthc_result_checker.sv
tb/sv/testbench.sv
